// ----- rtl/rgb2ycc_pkg.sv -----
// Shared types and constants for the RGB to YCbCr pixel converter.
// Holds the configuration register map, the register bundle and the datapath widths.
// Depends on nothing; every other file in rtl refers to it by scoped names.
package rgb2ycc_pkg;

	localparam int CH_W      = 8;   // colour sample width
	localparam int COORD_W   = 15;  // column and row width
	localparam int KNEE_W    = 9;
	localparam int EPS_W     = 16;
	localparam int WGT_W     = 17;  // luma weights and chroma scales
	localparam int BIAS_W    = 8;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DW    = 17;  // widest register

	// Curved channel, signed Q16 in units of 1/255.
	localparam int P_W    = 25;
	localparam int SAG_W  = EPS_W + CH_W;
	// Weighted channel, sum of three weighted channels, chroma difference.
	localparam int PROD_W = P_W + WGT_W + 1;
	localparam int Y_W    = PROD_W + 2;
	localparam int DIFF_W = Y_W + 1;
	// The chroma difference is multiplied in two halves.
	localparam int LO_W   = 23;
	localparam int HI_W   = DIFF_W - LO_W;
	localparam int LOP_W  = LO_W + WGT_W;
	localparam int HIP_W  = HI_W + WGT_W + 1;
	localparam int ACC_W  = 64;

	// Fractional bits of luma (Q32) and chroma (Q48) before the final floor.
	localparam int Y_FRAC = 32;
	localparam int C_FRAC = 48;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KNEE_LEVEL   = 3'd0,
		REG_GAMMA_OFFSET = 3'd1,
		REG_RED_WEIGHT   = 3'd2,
		REG_GREEN_WEIGHT = 3'd3,
		REG_BLUE_WEIGHT  = 3'd4,
		REG_BLUE_SCALE   = 3'd5,
		REG_RED_SCALE    = 3'd6,
		REG_CHROMA_BIAS  = 3'd7
	} cfg_reg_t;

	localparam logic [KNEE_W-1:0] RST_KNEE_LEVEL   = 9'd26;
	localparam logic [EPS_W-1:0]  RST_GAMMA_OFFSET = 16'd66;
	localparam logic [WGT_W-1:0]  RST_RED_WEIGHT   = 17'd16384;
	localparam logic [WGT_W-1:0]  RST_GREEN_WEIGHT = 17'd32768;
	localparam logic [WGT_W-1:0]  RST_BLUE_WEIGHT  = 17'd16384;
	localparam logic [WGT_W-1:0]  RST_BLUE_SCALE   = 17'd43691;
	localparam logic [WGT_W-1:0]  RST_RED_SCALE    = 17'd43691;
	localparam logic [BIAS_W-1:0] RST_CHROMA_BIAS  = 8'd128;

	typedef struct packed {
		logic [KNEE_W-1:0] knee_level;
		logic [EPS_W-1:0]  gamma_offset;
		logic [WGT_W-1:0]  red_weight;
		logic [WGT_W-1:0]  green_weight;
		logic [WGT_W-1:0]  blue_weight;
		logic [WGT_W-1:0]  blue_scale;
		logic [WGT_W-1:0]  red_scale;
		logic [BIAS_W-1:0] chroma_bias;
	} cfg_t;

	typedef struct packed {
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
	} coord_t;

endpackage

// ----- rtl/rgb2ycc_cfg.sv -----
// Configuration register file of the RGB to YCbCr pixel converter.
// Decodes the plain write port into the register bundle rgb2ycc_pkg::cfg_t.
// Depends on rgb2ycc_pkg.
module rgb2ycc_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [rgb2ycc_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [rgb2ycc_pkg::CFG_DW-1:0]      cfg_wdata,
	output rgb2ycc_pkg::cfg_t                   cfg
);

	rgb2ycc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.knee_level   <= rgb2ycc_pkg::RST_KNEE_LEVEL;
			cfg_q.gamma_offset <= rgb2ycc_pkg::RST_GAMMA_OFFSET;
			cfg_q.red_weight   <= rgb2ycc_pkg::RST_RED_WEIGHT;
			cfg_q.green_weight <= rgb2ycc_pkg::RST_GREEN_WEIGHT;
			cfg_q.blue_weight  <= rgb2ycc_pkg::RST_BLUE_WEIGHT;
			cfg_q.blue_scale   <= rgb2ycc_pkg::RST_BLUE_SCALE;
			cfg_q.red_scale    <= rgb2ycc_pkg::RST_RED_SCALE;
			cfg_q.chroma_bias  <= rgb2ycc_pkg::RST_CHROMA_BIAS;
		end else if (cfg_we) begin
			unique case (rgb2ycc_pkg::cfg_reg_t'(cfg_idx))
				rgb2ycc_pkg::REG_KNEE_LEVEL:
					cfg_q.knee_level <= cfg_wdata[rgb2ycc_pkg::KNEE_W-1:0];
				rgb2ycc_pkg::REG_GAMMA_OFFSET:
					cfg_q.gamma_offset <= cfg_wdata[rgb2ycc_pkg::EPS_W-1:0];
				rgb2ycc_pkg::REG_RED_WEIGHT:
					cfg_q.red_weight <= cfg_wdata[rgb2ycc_pkg::WGT_W-1:0];
				rgb2ycc_pkg::REG_GREEN_WEIGHT:
					cfg_q.green_weight <= cfg_wdata[rgb2ycc_pkg::WGT_W-1:0];
				rgb2ycc_pkg::REG_BLUE_WEIGHT:
					cfg_q.blue_weight <= cfg_wdata[rgb2ycc_pkg::WGT_W-1:0];
				rgb2ycc_pkg::REG_BLUE_SCALE:
					cfg_q.blue_scale <= cfg_wdata[rgb2ycc_pkg::WGT_W-1:0];
				rgb2ycc_pkg::REG_RED_SCALE:
					cfg_q.red_scale <= cfg_wdata[rgb2ycc_pkg::WGT_W-1:0];
				rgb2ycc_pkg::REG_CHROMA_BIAS:
					cfg_q.chroma_bias <= cfg_wdata[rgb2ycc_pkg::BIAS_W-1:0];
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- rtl/rgb2ycc_curve.sv -----
// Transfer curve stage for one colour channel (first pipeline stage).
// Produces the curved channel as signed Q16 in units of 1/255, registered.
// Depends on rgb2ycc_pkg.
module rgb2ycc_curve (
	input  logic                                      clk,
	input  logic [rgb2ycc_pkg::CH_W-1:0]              sample,
	input  logic [rgb2ycc_pkg::KNEE_W-1:0]            knee_level,
	input  logic [rgb2ycc_pkg::EPS_W-1:0]             gamma_offset,
	output logic signed [rgb2ycc_pkg::P_W-1:0]        curved_s1
);

	localparam int LIN_W = rgb2ycc_pkg::P_W - 1;

	logic [rgb2ycc_pkg::CH_W-1:0]           headroom;
	logic [rgb2ycc_pkg::SAG_W-1:0]          sag;
	logic [LIN_W-1:0]                       lin;
	logic signed [rgb2ycc_pkg::P_W-1:0]     upper;
	logic                                   below_knee;

	// The upper segment sags below the line by eps * (255 - c).
	assign headroom   = {rgb2ycc_pkg::CH_W{1'b1}} - sample;
	assign sag        = rgb2ycc_pkg::SAG_W'(gamma_offset) * rgb2ycc_pkg::SAG_W'(headroom);
	assign lin        = {sample, 16'h0000};
	assign upper      = $signed({1'b0, lin}) - $signed({1'b0, sag});
	assign below_knee = ({1'b0, sample} < knee_level);

	always_ff @(posedge clk) begin
		curved_s1 <= below_knee ? $signed({1'b0, lin}) : upper;
	end

endmodule

// ----- rtl/rgb2ycc_chroma.sv -----
// Chroma path for one difference channel (pipeline stages four to six).
// Forms (P*2^16 - Y) * scale + bias*2^48, with the wide product split in two halves,
// then floors and clamps to 0..255. Depends on rgb2ycc_pkg.
module rgb2ycc_chroma (
	input  logic                                      clk,
	input  logic signed [rgb2ycc_pkg::P_W-1:0]        curved_s3,
	input  logic signed [rgb2ycc_pkg::Y_W-1:0]        luma_q_s3,
	input  logic [rgb2ycc_pkg::WGT_W-1:0]             scale,
	input  logic [rgb2ycc_pkg::BIAS_W-1:0]            bias,
	output logic [rgb2ycc_pkg::CH_W-1:0]              chroma_s6
);

	localparam int DIFF_W = rgb2ycc_pkg::DIFF_W;
	localparam int LO_W   = rgb2ycc_pkg::LO_W;
	localparam int HI_W   = rgb2ycc_pkg::HI_W;
	localparam int LOP_W  = rgb2ycc_pkg::LOP_W;
	localparam int HIP_W  = rgb2ycc_pkg::HIP_W;
	localparam int ACC_W  = rgb2ycc_pkg::ACC_W;
	localparam int C_FRAC = rgb2ycc_pkg::C_FRAC;
	localparam int CH_W   = rgb2ycc_pkg::CH_W;

	logic signed [DIFF_W-1:0] diff_d;
	logic signed [DIFF_W-1:0] diff_s4;
	logic [LOP_W-1:0]         lo_prod_d;
	logic signed [HIP_W-1:0]  hi_prod_d;
	logic [LOP_W-1:0]         lo_prod_s5;
	logic signed [HIP_W-1:0]  hi_prod_s5;
	logic signed [ACC_W-1:0]  hi_ext;
	logic [ACC_W-1:0]         lo_ext;
	logic [ACC_W-1:0]         bias_ext;
	logic [ACC_W-1:0]         acc;
	logic [CH_W-1:0]          clamped;

	assign diff_d = DIFF_W'($signed({curved_s3, 16'h0000})) - DIFF_W'(luma_q_s3);

	always_ff @(posedge clk) begin
		diff_s4 <= diff_d;
	end

	// Low half is unsigned, high half carries the sign.
	assign lo_prod_d = LOP_W'(diff_s4[LO_W-1:0]) * LOP_W'(scale);
	assign hi_prod_d = HIP_W'($signed(diff_s4[DIFF_W-1:LO_W])) * HIP_W'($signed({1'b0, scale}));

	always_ff @(posedge clk) begin
		lo_prod_s5 <= lo_prod_d;
		hi_prod_s5 <= hi_prod_d;
	end

	// The full sum stays well inside 63 bits, so bit 63 is its sign.
	assign hi_ext   = ACC_W'(hi_prod_s5);
	assign lo_ext   = ACC_W'(lo_prod_s5);
	assign bias_ext = {bias, {C_FRAC{1'b0}}};
	assign acc      = ACC_W'(hi_ext <<< LO_W) + lo_ext + bias_ext;

	always_comb begin
		if (acc[ACC_W-1]) begin
			clamped = '0;
		end else if (|acc[ACC_W-2:C_FRAC+CH_W]) begin
			clamped = {CH_W{1'b1}};
		end else begin
			clamped = acc[C_FRAC+CH_W-1:C_FRAC];
		end
	end

	always_ff @(posedge clk) begin
		chroma_s6 <= clamped;
	end

endmodule

// ----- rtl/rgb_gamma_to_ycbcr_pixel_core.sv -----
// Top level of the RGB to YCbCr pixel converter with a two-segment transfer curve.
// Instantiates the register file, three channel curve stages and two chroma paths.
// Depends on rgb2ycc_pkg, rgb2ycc_cfg, rgb2ycc_curve and rgb2ycc_chroma.
//
// Use of the block:
// A request carries one RGB pixel with its column and row and is taken at a rising
// clock edge at which start is high and busy is low. Busy is low at all times except
// from reset until the first clock edge after arst_n is released, so a new request may
// be issued on every cycle: the block takes one pixel per clock.
// Each request gives exactly one result. It appears on luma_out, cb_out, cr_out, col_out
// and row_out for a single cycle, marked by done, after passing through the six
// register stages of the datapath: curve, weighting, luma sum, chroma difference, split
// chroma product, and the final sum with floor and clamp. Results leave in request order
// and cannot be held off, so the pipeline never stalls and needs no back pressure.
// Configuration registers are written through cfg_we, cfg_idx and cfg_wdata;
// they should change only while no request is in flight.
// Reset clears the stage valid bits, so nothing emerges after reset, and returns every
// configuration register to its default value.
module rgb_gamma_to_ycbcr_pixel_core (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    start,
	output logic                                    busy,
	input  logic [rgb2ycc_pkg::CH_W-1:0]            red_in,
	input  logic [rgb2ycc_pkg::CH_W-1:0]            green_in,
	input  logic [rgb2ycc_pkg::CH_W-1:0]            blue_in,
	input  logic [rgb2ycc_pkg::COORD_W-1:0]         col_in,
	input  logic [rgb2ycc_pkg::COORD_W-1:0]         row_in,
	input  logic                                    cfg_we,
	input  logic [rgb2ycc_pkg::CFG_IDX_W-1:0]       cfg_idx,
	input  logic [rgb2ycc_pkg::CFG_DW-1:0]          cfg_wdata,
	output logic                                    done,
	output logic [rgb2ycc_pkg::CH_W-1:0]            luma_out,
	output logic [rgb2ycc_pkg::CH_W-1:0]            cb_out,
	output logic [rgb2ycc_pkg::CH_W-1:0]            cr_out,
	output logic [rgb2ycc_pkg::COORD_W-1:0]         col_out,
	output logic [rgb2ycc_pkg::COORD_W-1:0]         row_out
);

	localparam int P_W    = rgb2ycc_pkg::P_W;
	localparam int PROD_W = rgb2ycc_pkg::PROD_W;
	localparam int Y_W    = rgb2ycc_pkg::Y_W;
	localparam int Y_FRAC = rgb2ycc_pkg::Y_FRAC;
	localparam int CH_W   = rgb2ycc_pkg::CH_W;

	rgb2ycc_pkg::cfg_t   cfg;
	logic                busy_q;
	logic                take;

	// Valid bits and coordinates travel alongside the datapath.
	logic                v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	rgb2ycc_pkg::coord_t pos_s1, pos_s2, pos_s3, pos_s4, pos_s5, pos_s6;

	logic signed [P_W-1:0]    red_p_s1, green_p_s1, blue_p_s1;
	logic signed [P_W-1:0]    red_p_s2, blue_p_s2;
	logic signed [P_W-1:0]    red_p_s3, blue_p_s3;
	logic signed [PROD_W-1:0] red_w_s2, green_w_s2, blue_w_s2;
	logic signed [Y_W-1:0]    luma_q_s3;
	logic [CH_W-1:0]          luma_clamped;
	logic [CH_W-1:0]          luma_s4, luma_s5, luma_s6;
	logic [CH_W-1:0]          cb_s6, cr_s6;

	// Busy is set by reset and cleared by the clock once arst_n is released; afterwards a
	// request is taken on every cycle in which start is high.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
		end else begin
			busy_q <= 1'b0;
		end
	end

	assign busy = busy_q;
	assign take = start && !busy_q;

	rgb2ycc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// Stage one: the transfer curve on each channel.
	rgb2ycc_curve u_curve_red (
		.clk          (clk),
		.sample       (red_in),
		.knee_level   (cfg.knee_level),
		.gamma_offset (cfg.gamma_offset),
		.curved_s1    (red_p_s1)
	);

	rgb2ycc_curve u_curve_green (
		.clk          (clk),
		.sample       (green_in),
		.knee_level   (cfg.knee_level),
		.gamma_offset (cfg.gamma_offset),
		.curved_s1    (green_p_s1)
	);

	rgb2ycc_curve u_curve_blue (
		.clk          (clk),
		.sample       (blue_in),
		.knee_level   (cfg.knee_level),
		.gamma_offset (cfg.gamma_offset),
		.curved_s1    (blue_p_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s1 <= take;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		pos_s1 <= '{col: col_in, row: row_in};
		pos_s2 <= pos_s1;
		pos_s3 <= pos_s2;
		pos_s4 <= pos_s3;
		pos_s5 <= pos_s4;
		pos_s6 <= pos_s5;
	end

	// Stage two: each curved channel times its luma weight, one multiplier per channel.
	always_ff @(posedge clk) begin
		red_w_s2   <= PROD_W'($signed({1'b0, cfg.red_weight})) * PROD_W'(red_p_s1);
		green_w_s2 <= PROD_W'($signed({1'b0, cfg.green_weight})) * PROD_W'(green_p_s1);
		blue_w_s2  <= PROD_W'($signed({1'b0, cfg.blue_weight})) * PROD_W'(blue_p_s1);
		red_p_s2   <= red_p_s1;
		blue_p_s2  <= blue_p_s1;
	end

	// Stage three: luma in Q32.
	always_ff @(posedge clk) begin
		luma_q_s3 <= Y_W'(red_w_s2) + Y_W'(green_w_s2) + Y_W'(blue_w_s2);
		red_p_s3  <= red_p_s2;
		blue_p_s3 <= blue_p_s2;
	end

	// Luma is floored and clamped in stage four, then waits for the chroma paths.
	always_comb begin
		if (luma_q_s3[Y_W-1]) begin
			luma_clamped = '0;
		end else if (|luma_q_s3[Y_W-2:Y_FRAC+CH_W]) begin
			luma_clamped = {CH_W{1'b1}};
		end else begin
			luma_clamped = luma_q_s3[Y_FRAC+CH_W-1:Y_FRAC];
		end
	end

	always_ff @(posedge clk) begin
		luma_s4 <= luma_clamped;
		luma_s5 <= luma_s4;
		luma_s6 <= luma_s5;
	end

	// Stages four to six: blue and red differences against luma.
	rgb2ycc_chroma u_chroma_cb (
		.clk       (clk),
		.curved_s3 (blue_p_s3),
		.luma_q_s3 (luma_q_s3),
		.scale     (cfg.blue_scale),
		.bias      (cfg.chroma_bias),
		.chroma_s6 (cb_s6)
	);

	rgb2ycc_chroma u_chroma_cr (
		.clk       (clk),
		.curved_s3 (red_p_s3),
		.luma_q_s3 (luma_q_s3),
		.scale     (cfg.red_scale),
		.bias      (cfg.chroma_bias),
		.chroma_s6 (cr_s6)
	);

	assign done     = v_s6;
	assign luma_out = luma_s6;
	assign cb_out   = cb_s6;
	assign cr_out   = cr_s6;
	assign col_out  = pos_s6.col;
	assign row_out  = pos_s6.row;

endmodule

// ----- test/ycbcr_pixel_checker.sv -----
`timescale 1ns / 100ps
// Scoreboard for the RGB to YCbCr pixel converter: mirrors the configuration registers,
// predicts every converted pixel from the accepted requests and compares the results.
// Depends on rgb2ycc_pkg for the widths, the register indexes and the reset values.
module ycbcr_pixel_checker
	import rgb2ycc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic [CH_W-1:0]    red_in,
	input  logic [CH_W-1:0]    green_in,
	input  logic [CH_W-1:0]    blue_in,
	input  logic [COORD_W-1:0] col_in,
	input  logic [COORD_W-1:0] row_in,
	input  logic               cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_DW-1:0]  cfg_wdata,
	input  logic               done,
	input  logic [CH_W-1:0]    luma_out,
	input  logic [CH_W-1:0]    cb_out,
	input  logic [CH_W-1:0]    cr_out,
	input  logic [COORD_W-1:0] col_out,
	input  logic [COORD_W-1:0] row_out,
	output int                 failures,
	output int                 outstanding
);

	typedef struct packed {
		logic [CH_W-1:0]    luma;
		logic [CH_W-1:0]    cb;
		logic [CH_W-1:0]    cr;
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
	} ycc_pixel_t;

	cfg_t       cfg_mirror;
	ycc_pixel_t pending_pixels[$];
	int         fail_count;

	// Transfer curve of one channel, signed Q16 in units of 1/255.
	function automatic longint curve_channel(input logic [CH_W-1:0] c);
		longint cv, knee, eps;
		cv   = c;
		knee = cfg_mirror.knee_level;
		eps  = cfg_mirror.gamma_offset;
		if (cv < knee)
			return cv * 65536;
		return cv * 65536 - eps * (255 - cv);
	endfunction

	function automatic logic [CH_W-1:0] floor_clamp(input longint v, input int frac);
		longint q;
		if (v < 0)
			return '0;
		q = v >>> frac;
		if (q > 255)
			return 8'd255;
		return q[CH_W-1:0];
	endfunction

	function automatic ycc_pixel_t convert_pixel(input logic [CH_W-1:0] r, g, b,
			input logic [COORD_W-1:0] col, row);
		longint pr, pg, pb, wr, wg, wb, sb, sr, yq, bias48;
		ycc_pixel_t px;
		pr = curve_channel(r);
		pg = curve_channel(g);
		pb = curve_channel(b);
		wr = cfg_mirror.red_weight;
		wg = cfg_mirror.green_weight;
		wb = cfg_mirror.blue_weight;
		sb = cfg_mirror.blue_scale;
		sr = cfg_mirror.red_scale;
		bias48 = cfg_mirror.chroma_bias;
		bias48 = bias48 <<< 48;
		yq = wr * pr + wg * pg + wb * pb;
		px.luma = floor_clamp(yq, Y_FRAC);
		px.cb   = floor_clamp((pb * 65536 - yq) * sb + bias48, C_FRAC);
		px.cr   = floor_clamp((pr * 65536 - yq) * sr + bias48, C_FRAC);
		px.col  = col;
		px.row  = row;
		return px;
	endfunction

	function automatic int field_mismatch(input string name, input logic [31:0] want, got);
		if (got === want)
			return 0;
		$error("%s: expected %0d, got %0d", name, want, got);
		return 1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		ycc_pixel_t want;
		if (!arst_n) begin
			cfg_mirror.knee_level   = RST_KNEE_LEVEL;
			cfg_mirror.gamma_offset = RST_GAMMA_OFFSET;
			cfg_mirror.red_weight   = RST_RED_WEIGHT;
			cfg_mirror.green_weight = RST_GREEN_WEIGHT;
			cfg_mirror.blue_weight  = RST_BLUE_WEIGHT;
			cfg_mirror.blue_scale   = RST_BLUE_SCALE;
			cfg_mirror.red_scale    = RST_RED_SCALE;
			cfg_mirror.chroma_bias  = RST_CHROMA_BIAS;
			pending_pixels.delete();
			fail_count  = 0;
			failures    <= 0;
			outstanding <= 0;
		end else begin
			// Results are matched before new requests are queued, so a stray
			// result can never pair up with a request taken at the same edge.
			if (done) begin
				if (pending_pixels.size() == 0) begin
					$error("result (%0d,%0d,%0d) at col %0d row %0d with no request waiting",
						luma_out, cb_out, cr_out, col_out, row_out);
					fail_count++;
				end else begin
					want = pending_pixels.pop_front();
					fail_count += field_mismatch("luma_out", want.luma, luma_out);
					fail_count += field_mismatch("cb_out", want.cb, cb_out);
					fail_count += field_mismatch("cr_out", want.cr, cr_out);
					fail_count += field_mismatch("col_out", want.col, col_out);
					fail_count += field_mismatch("row_out", want.row, row_out);
				end
			end
			if (start && !busy)
				pending_pixels.push_back(convert_pixel(red_in, green_in, blue_in,
					col_in, row_in));
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_idx))
					REG_KNEE_LEVEL:   cfg_mirror.knee_level   = cfg_wdata[KNEE_W-1:0];
					REG_GAMMA_OFFSET: cfg_mirror.gamma_offset = cfg_wdata[EPS_W-1:0];
					REG_RED_WEIGHT:   cfg_mirror.red_weight   = cfg_wdata[WGT_W-1:0];
					REG_GREEN_WEIGHT: cfg_mirror.green_weight = cfg_wdata[WGT_W-1:0];
					REG_BLUE_WEIGHT:  cfg_mirror.blue_weight  = cfg_wdata[WGT_W-1:0];
					REG_BLUE_SCALE:   cfg_mirror.blue_scale   = cfg_wdata[WGT_W-1:0];
					REG_RED_SCALE:    cfg_mirror.red_scale    = cfg_wdata[WGT_W-1:0];
					REG_CHROMA_BIAS:  cfg_mirror.chroma_bias  = cfg_wdata[BIAS_W-1:0];
					default: ;
				endcase
			end
			failures    <= fail_count;
			outstanding <= pending_pixels.size();
		end
	end

endmodule

// ----- test/rgb_gamma_to_ycbcr_pixel_core_tb.sv -----
`timescale 1ns / 100ps
// Testbench top for the RGB to YCbCr pixel converter: drives requests and register writes
// and gives the verdict. Depends on rgb2ycc_pkg, the block and ycbcr_pixel_checker.
module rgb_gamma_to_ycbcr_pixel_core_tb;
	import rgb2ycc_pkg::*;

	// The slowest correct run is roughly a thousand requests with the sender idling most
	// heavily, plus short pauses between settings; the limit leaves a wide margin over
	// that.
	localparam int CYCLE_LIMIT        = 400000;
	// Pause added on top of the block's answer time before settings change.
	localparam int SETTLE_CYCLES      = 10;
	localparam int NUM_PHASES         = 8;
	localparam int RANDOM_PER_PHASE   = 112;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [CH_W-1:0]    red_in, green_in, blue_in;
	logic [COORD_W-1:0] col_in, row_in;
	logic               cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_DW-1:0]  cfg_wdata;
	logic               done;
	logic [CH_W-1:0]    luma_out, cb_out, cr_out;
	logic [COORD_W-1:0] col_out, row_out;

	int                 failures;
	int                 outstanding;
	int                 idle_pct;
	int                 pixels_sent;
	int                 cycle_count;
	logic [KNEE_W-1:0]  cur_knee;

	// Sender idling per phase: none, heavy, light, with idle-free stretches between.
	int idle_by_phase[NUM_PHASES] = '{0, 80, 25, 0, 80, 25, 0, 80};

	always #6 clk = ~clk;

	rgb_gamma_to_ycbcr_pixel_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.red_in    (red_in),
		.green_in  (green_in),
		.blue_in   (blue_in),
		.col_in    (col_in),
		.row_in    (row_in),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.done      (done),
		.luma_out  (luma_out),
		.cb_out    (cb_out),
		.cr_out    (cr_out),
		.col_out   (col_out),
		.row_out   (row_out)
	);

	// The scoreboard sits beside the block and sees exactly what the block sees.
	ycbcr_pixel_checker pixel_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.red_in      (red_in),
		.green_in    (green_in),
		.blue_in     (blue_in),
		.col_in      (col_in),
		.row_in      (row_in),
		.cfg_we      (cfg_we),
		.cfg_idx     (cfg_idx),
		.cfg_wdata   (cfg_wdata),
		.done        (done),
		.luma_out    (luma_out),
		.cb_out      (cb_out),
		.cr_out      (cr_out),
		.col_out     (col_out),
		.row_out     (row_out),
		.failures    (failures),
		.outstanding (outstanding)
	);

	// Samples lean towards the ends of the range and towards both sides of the knee,
	// where the transfer curve changes segment.
	function automatic logic [CH_W-1:0] pick_sample(input logic [KNEE_W-1:0] knee);
		int k;
		k = knee;
		case ($urandom_range(7))
			0: return 8'd0;
			1: return 8'd255;
			2: return (k >= 1 && k <= 256) ? 8'(k - 1) : 8'($urandom_range(255));
			3: return (k <= 255) ? 8'(k) : 8'd255;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	function automatic logic [COORD_W-1:0] pick_coord();
		case ($urandom_range(9))
			0: return '0;
			1: return 15'd32766;
			default: return 15'($urandom_range(32766));
		endcase
	endfunction

	// Each task is entered just after a rising edge and assigns every signal at most
	// once before waiting for the next edge, so start and cfg_we are never lowered and
	// raised again within one time step.
	task automatic send_pixel(input logic [CH_W-1:0] r, g, b,
			input logic [COORD_W-1:0] col, row);
		while ($urandom_range(99) < idle_pct) begin
			// Idle cycle: start is low and the payload carries noise that must be ignored.
			start    <= 1'b0;
			red_in   <= 8'($urandom);
			green_in <= 8'($urandom);
			blue_in  <= 8'($urandom);
			col_in   <= 15'($urandom);
			row_in   <= 15'($urandom);
			@(posedge clk);
		end
		start    <= 1'b1;
		red_in   <= r;
		green_in <= g;
		blue_in  <= b;
		col_in   <= col;
		row_in   <= row;
		// The request is taken at the first edge at which busy was low.
		do @(posedge clk); while (busy);
		pixels_sent++;
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DW-1:0] value);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= value;
		@(posedge clk);
	endtask

	task automatic apply_setting(input logic [CFG_DW-1:0] knee, eps, wr, wg, wb, sb, sr, bias);
		write_reg(REG_KNEE_LEVEL, knee);
		write_reg(REG_GAMMA_OFFSET, eps);
		write_reg(REG_RED_WEIGHT, wr);
		write_reg(REG_GREEN_WEIGHT, wg);
		write_reg(REG_BLUE_WEIGHT, wb);
		write_reg(REG_BLUE_SCALE, sb);
		write_reg(REG_RED_SCALE, sr);
		write_reg(REG_CHROMA_BIAS, bias);
		cfg_we   <= 1'b0;
		cur_knee = knee[KNEE_W-1:0];
	endtask

	// Stops issuing requests and waits until every predicted pixel has come back,
	// then lets the pipeline settle before any register is touched.
	task automatic drain_pipeline();
		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		arst_n    <= 1'b0;
		start     <= 1'b0;
		red_in    <= '0;
		green_in  <= '0;
		blue_in   <= '0;
		col_in    <= '0;
		row_in    <= '0;
		cfg_we    <= 1'b0;
		cfg_idx   <= REG_KNEE_LEVEL;
		cfg_wdata <= '0;
		idle_pct    = 0;
		pixels_sent = 0;
		cur_knee    = RST_KNEE_LEVEL;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed requests under the reset settings: black at coordinate 0 and white at
		// coordinate 32766, the primaries and secondaries, both sides of the
		// default knee, mid grey, and alternating bit patterns on every field.
		send_pixel(8'd0, 8'd0, 8'd0, 15'd0, 15'd0);
		send_pixel(8'd255, 8'd255, 8'd255, 15'd32766, 15'd32766);
		send_pixel(8'd255, 8'd0, 8'd0, 15'd1, 15'd0);
		send_pixel(8'd0, 8'd255, 8'd0, 15'd0, 15'd1);
		send_pixel(8'd0, 8'd0, 8'd255, 15'd2, 15'd2);
		send_pixel(8'd255, 8'd0, 8'd255, 15'd3, 15'd3);
		send_pixel(8'd0, 8'd255, 8'd255, 15'd4, 15'd4);
		send_pixel(8'd255, 8'd255, 8'd0, 15'd5, 15'd5);
		send_pixel(8'd25, 8'd25, 8'd25, 15'd6, 15'd6);
		send_pixel(8'd26, 8'd26, 8'd26, 15'd7, 15'd7);
		send_pixel(8'd27, 8'd25, 8'd26, 15'd8, 15'd8);
		send_pixel(8'd128, 8'd128, 8'd128, 15'd16383, 15'd16384);
		send_pixel(8'h55, 8'hAA, 8'h55, 15'h5555, 15'h2AAA);
		send_pixel(8'hAA, 8'h55, 8'hAA, 15'h2AAA, 15'h5555);

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			drain_pipeline();
			case (ph)
				// Defaults written back explicitly.
				0: apply_setting(CFG_DW'(RST_KNEE_LEVEL), CFG_DW'(RST_GAMMA_OFFSET),
					CFG_DW'(RST_RED_WEIGHT), CFG_DW'(RST_GREEN_WEIGHT),
					CFG_DW'(RST_BLUE_WEIGHT), CFG_DW'(RST_BLUE_SCALE),
					CFG_DW'(RST_RED_SCALE), CFG_DW'(RST_CHROMA_BIAS));
				// Broadcast-style luma weights with a realistic curve.
				1: apply_setting(19, 6488, 19595, 38470, 7471, 36984, 46745, 128);
				// Knee of zero puts every channel on the upper segment, which goes
				// negative for dark samples; everything else is at its maximum.
				2: apply_setting(0, 65535, 131071, 131071, 131071, 131071, 131071, 255);
				// Knee far above 255 keeps every channel linear; all else at zero.
				3: apply_setting(511, 0, 0, 0, 0, 0, 0, 0);
				// Knee just above 255 with lopsided weights and a saturating Cb scale.
				4: apply_setting(256, 65535, 65536, 0, 0, 131071, 65536, 0);
				// Only full white reaches the upper segment.
				5: apply_setting(255, CFG_DW'($urandom_range(65535)),
					CFG_DW'($urandom_range(32768)), CFG_DW'($urandom_range(32768)),
					CFG_DW'($urandom_range(32768)), CFG_DW'($urandom_range(65535)),
					CFG_DW'($urandom_range(65535)), CFG_DW'($urandom_range(255)));
				default: apply_setting(CFG_DW'($urandom_range(511)),
					CFG_DW'($urandom_range(65535)), CFG_DW'($urandom_range(65536)),
					CFG_DW'($urandom_range(65536)), CFG_DW'($urandom_range(65536)),
					CFG_DW'($urandom_range(131071)), CFG_DW'($urandom_range(131071)),
					CFG_DW'($urandom_range(255)));
			endcase
			idle_pct = idle_by_phase[ph];
			repeat (RANDOM_PER_PHASE)
				send_pixel(pick_sample(cur_knee), pick_sample(cur_knee),
					pick_sample(cur_knee), pick_coord(), pick_coord());
		end
		drain_pipeline();

		$display("Converted %0d pixels under the reset registers and %0d written settings,",
			pixels_sent, NUM_PHASES);
		$display("covering knees of 0, 255, 256 and 511, saturated weights and idle rates of 0/25/80%%.");
		if (failures == 0)
			$display("rgb_gamma_to_ycbcr_pixel_core_tb: clean");
		else
			$display("rgb_gamma_to_ycbcr_pixel_core_tb: errors");
		$finish;
	end

	// Watchdog: a hang anywhere, such as busy stuck high or a result that never
	// arrives, ends the run as a failure.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Run stopped after %0d cycles without finishing.", CYCLE_LIMIT);
		$display("rgb_gamma_to_ycbcr_pixel_core_tb: errors");
		$finish;
	end

endmodule
